>>> hdl/gsmaa_pkg.sv
// Shared constants and controller/datapath interface types for the gas sample averager.
package gsmaa_pkg;

   // Field and register widths.
   localparam int SAMPLE_W    = 12;
   localparam int LIMIT_W     = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   // Default ring depth.
   localparam int WINDOW_DEF = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSPECT_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARN_LEVEL    = 1'd1;

   // Configuration reset values.
   localparam logic [LIMIT_W-1:0]  SUSPECT_LIMIT_RST = 13'd4000;
   localparam logic [SAMPLE_W-1:0] WARN_LEVEL_RST    = 12'd1500;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the request sample and pick the used value
      logic update;    // update sum, ring and pointer, and start the divider
      logic div_step;  // one restoring division step
      logic out_load;  // move the finished result into the output register
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // output register can take a new result this cycle
   } ctl_status_type;

endpackage

>>> hdl/gsmaa_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module gsmaa_ctrl #(
   parameter int WINDOW = gsmaa_pkg::WINDOW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  gsmaa_pkg::ctl_status_type status,
   output gsmaa_pkg::ctl_cmd_type    cmd
);
   import gsmaa_pkg::*;

   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

   // State codes.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_OUT    = 3'd3;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // A new request is taken only when the sequencer is idle.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state, step count and commands.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.load     = 1'b0;
      cmd.update   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

`ifndef SYNTH
   // At most one datapath command is issued per cycle.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.update, cmd.div_step, cmd.out_load}))
      else $error("more than one datapath command at once");

   // A result is never loaded into a busy output register.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded while output register busy");

   // A captured request is always followed by the ring and sum update.
   a_load_update: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.update)
      else $error("update did not follow request capture");
`endif

endmodule

>>> hdl/gsmaa_dpath.sv
// Datapath: configuration, outlier hold, sample ring, running sum, divider and output register.
module gsmaa_dpath #(
   parameter int WINDOW = gsmaa_pkg::WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [gsmaa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gsmaa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [gsmaa_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [gsmaa_pkg::SAMPLE_W-1:0]       rsp_used_value,
   output logic                                 rsp_suspect,
   output logic [gsmaa_pkg::SAMPLE_W-1:0]       rsp_mean_value,
   output logic                                 rsp_alarm,
   input  gsmaa_pkg::ctl_cmd_type               cmd,
   output gsmaa_pkg::ctl_status_type            status
);
   import gsmaa_pkg::*;

   localparam int PTR_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);

   // Configuration registers.
   logic [LIMIT_W-1:0]  limit_ff;
   logic [SAMPLE_W-1:0] warn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= SUSPECT_LIMIT_RST;
         warn_ff  <= WARN_LEVEL_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SUSPECT_LIMIT: limit_ff <= csr_write_data[LIMIT_W-1:0];
            CSR_WARN_LEVEL:    warn_ff  <= csr_write_data[SAMPLE_W-1:0];
            default:           limit_ff <= limit_ff;
         endcase
      end
   end

   // Outlier hold: a sample at or above the limit is replaced by the last good one.
   logic [SAMPLE_W-1:0] last_ff;
   logic [SAMPLE_W-1:0] used_ff;
   logic                suspect_ff;
   logic                is_suspect;

   assign is_suspect = ({1'b0, req_sample} >= limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (cmd.load && !is_suspect) begin
         last_ff <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         used_ff    <= is_suspect ? last_ff : req_sample;
         suspect_ff <= is_suspect;
      end
   end

   // Sample ring with one write port and one registered read port at the write pointer.
   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]    pos_ff, pos_in;
   logic                full_ff, full_in;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[pos_ff] <= used_ff;
      end
      rd_data_ff <= ring_mem[pos_ff];
   end

   // Pointer advance and wrap.
   always_comb begin
      pos_in  = pos_ff + 1'b1;
      full_in = full_ff;
      if (pos_ff == PTR_LAST) begin
         pos_in  = '0;
         full_in = 1'b1;
      end
   end

   // Running sum and fill count; the oldest entry leaves the sum once the ring is full.
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff;

   assign sum_in = sum_ff - (full_ff ? SUM_W'(rd_data_ff) : '0) + SUM_W'(used_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         full_ff <= 1'b0;
         sum_ff  <= '0;
      end else if (cmd.update) begin
         pos_ff  <= pos_in;
         full_ff <= full_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         count_ff <= full_in ? WIN_CNT : CNT_W'(pos_in);
      end
   end

   // Restoring divider: one quotient bit per step, dividend shifted out of the quotient register.
   logic [SUM_W-1:0] quo_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [CNT_W:0]   rem_shift;
   logic             quo_bit;

   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign quo_bit   = (rem_shift >= {1'b0, count_ff});

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         quo_ff <= sum_in;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], quo_bit};
         rem_ff <= quo_bit ? CNT_W'(rem_shift - {1'b0, count_ff}) : rem_shift[CNT_W-1:0];
      end
   end

   // Output register; it frees up in the same cycle that its result is taken.
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_used_ff;
   logic                rsp_suspect_ff;
   logic [SAMPLE_W-1:0] rsp_mean_ff;
   logic                rsp_alarm_ff;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_used_ff    <= used_ff;
         rsp_suspect_ff <= suspect_ff;
         rsp_mean_ff    <= quo_ff[SAMPLE_W-1:0];
         rsp_alarm_ff   <= (quo_ff[SAMPLE_W-1:0] >= warn_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_used_value = rsp_used_ff;
   assign rsp_suspect    = rsp_suspect_ff;
   assign rsp_mean_value = rsp_mean_ff;
   assign rsp_alarm      = rsp_alarm_ff;

`ifndef SYNTH
   // Once the ring has wrapped it stays full.
   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("ring full flag dropped");

   // The divider remainder stays below the divisor.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < count_ff))
      else $error("divider remainder out of range");

   // A loaded result is presented in the next cycle.
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

>>> hdl/gas_sample_moving_average_alarm_core.sv
// Top level of the gas sample moving-average filter with outlier hold and alarm.
// Each request carries one 12-bit sample. A sample at or above suspect_limit is replaced by the
// last good sample. The used value enters a ring of WINDOW entries, and the result gives the
// truncated mean of the filled entries and an alarm when that mean reaches warn_level. One
// request keeps the block busy through these steps: it is accepted and the ring entry is read,
// the sum and ring are updated, the bit-serial restoring divider runs SUM_W steps, where
// SUM_W = 12 + clog2(WINDOW), and the result is loaded into the output register once that is
// free. Only one request is handled at a time: a new request is taken once the previous result
// sits in the output register, even while that result is still stalled. The ring needs no
// clearing after reset.
module gas_sample_moving_average_alarm_core #(
   parameter int WINDOW = gsmaa_pkg::WINDOW_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [gsmaa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gsmaa_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gsmaa_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gsmaa_pkg::SAMPLE_W-1:0]    rsp_used_value,
   output logic                              rsp_suspect,
   output logic [gsmaa_pkg::SAMPLE_W-1:0]    rsp_mean_value,
   output logic                              rsp_alarm
);
   import gsmaa_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // Sequencer.
   gsmaa_ctrl #(
      .WINDOW (WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   gsmaa_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_sample),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_used_value   (rsp_used_value),
      .rsp_suspect      (rsp_suspect),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_alarm        (rsp_alarm),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

>>> tb/gas_sample_moving_average_alarm_core_test.sv
// Self-checking testbench for the gas sample moving-average filter with outlier hold and alarm.
module gas_sample_moving_average_alarm_core_test;
   import gsmaa_pkg::*;

   localparam int RING_DEPTH  = WINDOW_DEF;
   localparam int SUM_W       = SAMPLE_W + $clog2(RING_DEPTH);
   localparam int SETTLE      = 25;       // settle time, longer than one request-to-result pass
   localparam int LONG_HOLD   = 400;      // receiver hold-off used to back the block up
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 8;

   // One result of the block, in port order.
   typedef struct packed {
      logic [SAMPLE_W-1:0] used_value;
      logic                suspect;
      logic [SAMPLE_W-1:0] mean_value;
      logic                alarm;
   } avg_result_type;

   // Tracks the filter state and holds the results still owed by the block.
   class mean_alarm_scoreboard;
      logic [SAMPLE_W-1:0] ring [RING_DEPTH];
      int unsigned         wr_pos;
      bit                  wrapped;
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] last_good;
      logic [LIMIT_W-1:0]  limit;
      logic [SAMPLE_W-1:0] warn;
      avg_result_type      owed_results[$];
      int unsigned         errors;
      int unsigned         checked;
      int unsigned         suspects;
      int unsigned         alarms;

      function new();
         wr_pos    = 0;
         wrapped   = 0;
         sum       = '0;
         last_good = '0;
         limit     = SUSPECT_LIMIT_RST;
         warn      = WARN_LEVEL_RST;
         errors    = 0;
         checked   = 0;
         suspects  = 0;
         alarms    = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_SUSPECT_LIMIT) begin
            limit = data[LIMIT_W-1:0];
         end else if (idx == CSR_WARN_LEVEL) begin
            warn = data[SAMPLE_W-1:0];
         end
      endfunction

      // Works out the result of one accepted request and queues it.
      function void note_sample(logic [SAMPLE_W-1:0] raw);
         avg_result_type r;
         int unsigned    fill;
         if ({1'b0, raw} >= limit) begin
            r.used_value = last_good;
            r.suspect    = 1'b1;
         end else begin
            r.used_value = raw;
            last_good    = raw;
            r.suspect    = 1'b0;
         end
         // Drop the oldest entry once the ring has wrapped, then add the new one.
         if (wrapped) begin
            sum = sum - ring[wr_pos];
         end
         ring[wr_pos] = r.used_value;
         sum = sum + r.used_value;
         wr_pos++;
         if (wr_pos >= RING_DEPTH) begin
            wr_pos  = 0;
            wrapped = 1;
         end
         fill = wrapped ? RING_DEPTH : wr_pos;
         r.mean_value = SAMPLE_W'(sum / fill);
         r.alarm = (r.mean_value >= warn);
         owed_results.push_back(r);
      endfunction

      // Compares one accepted result with the oldest one owed.
      function void check_result(avg_result_type got);
         avg_result_type want;
         if (owed_results.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: result with none owed: used %0d suspect %0d mean %0d alarm %0d",
                        got.used_value, got.suspect, got.mean_value, got.alarm);
            end
            return;
         end
         want = owed_results.pop_front();
         checked++;
         if (want.suspect) suspects++;
         if (want.alarm) alarms++;
         if (got.used_value !== want.used_value || got.suspect !== want.suspect ||
             got.mean_value !== want.mean_value || got.alarm !== want.alarm) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: result %0d: expected used %0d suspect %0d mean %0d alarm %0d",
                        checked, want.used_value, want.suspect, want.mean_value, want.alarm);
               $display("       got      used %0d suspect %0d mean %0d alarm %0d",
                        got.used_value, got.suspect, got.mean_value, got.alarm);
            end
         end
      endfunction

      function int unsigned pending();
         return owed_results.size();
      endfunction
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_SUSPECT_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_W-1:0]    req_sample       = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_used_value;
   logic                   rsp_suspect;
   logic [SAMPLE_W-1:0]    rsp_mean_value;
   logic                   rsp_alarm;

   mean_alarm_scoreboard sb = new();

   int unsigned cycle_count       = 0;
   int unsigned send_idle_pct     = 0;
   int unsigned recv_stall_pct    = 0;
   bit          long_hold_pending = 0;
   int unsigned settings_used     = 1;

   gas_sample_moving_average_alarm_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_used_value   (rsp_used_value),
      .rsp_suspect      (rsp_suspect),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_alarm        (rsp_alarm)
   );

   // Free-running clock.
   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results owed", cycle_count, sb.pending());
         $display("Mismatches found");
         $finish;
      end
   end

   // Both handshakes are observed at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_sample(req_sample);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result('{rsp_used_value, rsp_suspect, rsp_mean_value, rsp_alarm});
      end
   end

   // Receiver: random stalls, or one long hold-off when asked for.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Offers one request and holds it until the block takes it.
   task automatic drive_sample(input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Waits until every owed result is back and the block has settled.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Writes both registers on consecutive cycles.
   task automatic write_config(input logic [CSR_DATA_W-1:0] limit_data,
                               input logic [CSR_DATA_W-1:0] warn_data);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SUSPECT_LIMIT;
      csr_write_data   <= limit_data;
      @(negedge clock);
      sb.write_reg(CSR_SUSPECT_LIMIT, limit_data);
      csr_index        <= CSR_WARN_LEVEL;
      csr_write_data   <= warn_data;
      @(negedge clock);
      sb.write_reg(CSR_WARN_LEVEL, warn_data);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // Random sample: a mix of uniform values, extremes and values near the limit and the warn level.
   function automatic logic [SAMPLE_W-1:0] pick_sample(int lim, int lvl);
      int v;
      case ($urandom_range(9))
         0: v = 0;
         1: v = 4095;
         2, 3: v = lim + int'($urandom_range(4)) - 2;
         4, 5: v = lvl + int'($urandom_range(600)) - 300;
         default: v = $urandom_range(4095);
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return SAMPLE_W'(v);
   endfunction

   // Main sequence: directed requests, then random phases over several settings.
   initial begin
      logic [SAMPLE_W-1:0]   directed [20];
      logic [CSR_DATA_W-1:0] limits   [NUM_PHASES];
      logic [CSR_DATA_W-1:0] warns    [NUM_PHASES];
      int unsigned           counts   [NUM_PHASES];
      int unsigned           idle_tab [4];
      int unsigned           stall_tab[4];
      int                    lim;
      int                    lvl;

      directed = '{12'd4095, 12'd0, 12'd4095, 12'd4000, 12'd3999, 12'd4001, 12'd1, 12'd4094,
                   12'd2048, 12'd1500, 12'd1499, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd3999,
                   12'd1501, 12'd4001, 12'd0, 12'd2730};
      limits   = '{13'd4096, 13'd0, 13'd4095, 13'd1, 13'd4000,
                   13'($urandom_range(4096)), 13'd2048, 13'($urandom_range(4096))};
      warns    = '{13'd0, 13'd4095, 13'h1FFF, 13'd1, 13'd1500,
                   13'($urandom_range(8191)), 13'($urandom_range(8191)), 13'd2047};
      counts   = '{110, 50, 110, 60, 130, 110, 90, 70};
      idle_tab  = '{0, 63, 0, 31};
      stall_tab = '{0, 0, 63, 31};

      // Hold synchronous reset, then release it at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at reset settings: suspect before any good sample, limit edges, wrap.
      foreach (directed[i]) begin
         drive_sample(directed[i]);
      end

      // Random phases, each with its own setting and idling mix.
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_config(limits[p], warns[p]);
         send_idle_pct  = idle_tab[p % 4];
         recv_stall_pct = stall_tab[p % 4];
         if (p == 4) begin
            long_hold_pending = 1;
         end
         lim = int'(limits[p]);
         lvl = int'(warns[p][SAMPLE_W-1:0]);
         for (int n = 0; n < counts[p]; n++) begin
            drive_sample(pick_sample(lim, lvl));
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);

      $display("Checked %0d results over %0d register settings: %0d suspect, %0d with alarm.",
               sb.checked, settings_used, sb.suspects, sb.alarms);
      $display("Idling mixes on both sides and one long receiver hold-off were exercised.");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d errors, %0d results still owed", sb.errors, sb.pending());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> gas_sample_moving_average_alarm_core.f
hdl/gsmaa_pkg.sv
hdl/gsmaa_ctrl.sv
hdl/gsmaa_dpath.sv
hdl/gas_sample_moving_average_alarm_core.sv
tb/gas_sample_moving_average_alarm_core_test.sv
